@@ hdl/sas_pkg.sv @@
// Shared types and constants for the signed array sorter.
// Used by sas_ctrl, sas_dp and signed_array_sorter_core; no dependencies.
package sas_pkg;

  localparam int DEPTH_DEF = 64;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_LOAD_RD,
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic collect;  // take input items into the store
    logic ld_rd;    // read the store at the pass index
    logic ld_cap;   // capture the pass head, start the scan after it
    logic sc_rd;    // read the store at the scan index
    logic sc_cmp;   // compare, exchange, advance the scan index
    logic emit;     // load the output register, advance or close the run
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_acc;  // last item of a run accepted this cycle
    logic scan_end;  // scan index has reached the element count
    logic pass_last; // current pass is the final one
    logic out_free;  // output register can take an item
  } status_t;

endpackage

@@ hdl/signed_array_sorter_core.sv @@
// Top level of the signed array sorter: controller plus datapath.
// Depends on sas_pkg, sas_ctrl and sas_dp.
//
// The core collects a run of signed 32-bit items, one per cycle, until an
// item with last set arrives, then sorts the run with an exchange sort and
// sends it out, one item per value, last_out on the final one. Up to DEPTH
// values are kept; later ones are dropped and every item of that run then
// carries overflow. The descending register (cfg port, always ready) picks
// descending order when 1. While collecting, in_stall is low and the core
// takes one item per cycle. After the last item, in_stall stays high while
// the run is sorted and emitted, also through any output stall. The element
// store has one read port with a registered read, so each compare of a
// scan needs a read state and a compare state. Each pass keeps its running
// extreme in a register and emits it straight from there, so the next pass
// begins as soon as the output register takes the item.
module signed_array_sorter_core #(
  parameter int DEPTH = sas_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sas_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sas_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  sas_pkg::cmd_t    cmd;
  sas_pkg::status_t sts;

  // sequencer: advance through collect, pass load, scan and emit
  sas_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // store, counters, comparator and output register
  sas_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

@@ hdl/sas_ctrl.sv @@
// Sequencer for the signed array sorter: collect, exchange passes, emit.
// Depends on sas_pkg.
module sas_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  sas_pkg::status_t sts,
  output sas_pkg::cmd_t    cmd
);

  sas_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sas_pkg::ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      sas_pkg::ST_COLLECT: begin
        cmd.collect = 1'b1;
        if (sts.last_acc) begin
          state_nxt = sas_pkg::ST_LOAD_RD;
        end
      end
      sas_pkg::ST_LOAD_RD: begin
        cmd.ld_rd = 1'b1;
        state_nxt = sas_pkg::ST_LOAD;
      end
      sas_pkg::ST_LOAD: begin
        cmd.ld_cap = 1'b1;
        state_nxt  = sas_pkg::ST_SCAN_RD;
      end
      sas_pkg::ST_SCAN_RD: begin
        if (sts.scan_end) begin
          state_nxt = sas_pkg::ST_EMIT;
        end else begin
          cmd.sc_rd = 1'b1;
          state_nxt = sas_pkg::ST_SCAN_CMP;
        end
      end
      sas_pkg::ST_SCAN_CMP: begin
        cmd.sc_cmp = 1'b1;
        state_nxt  = sas_pkg::ST_SCAN_RD;
      end
      sas_pkg::ST_EMIT: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.pass_last) begin
            state_nxt = sas_pkg::ST_COLLECT;
          end else begin
            state_nxt = sas_pkg::ST_LOAD_RD;
          end
        end
      end
      default: begin
        state_nxt = sas_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

@@ hdl/sas_dp.sv @@
// Datapath of the signed array sorter: element store, counters, compare
// and exchange, output register. Depends on sas_pkg.
module sas_dp #(
  parameter int DEPTH = sas_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sas_pkg::cmd_t       cmd,
  output sas_pkg::status_t    sts,
  input  logic                in_valid,
  output logic                in_stall,
  input  sas_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sas_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];

  logic [CW-1:0]      count_r, count_nxt;
  logic               dropped_r, dropped_nxt;
  logic               desc_r;
  logic [AW-1:0]      pass_r;
  logic [CW-1:0]      scan_r;
  logic signed [31:0] cur_r;
  logic signed [31:0] rdata_r;
  logic               out_valid_r;
  sas_pkg::out_item_t out_r;

  logic               in_acc;
  logic               has_room;
  logic               swap;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [CW-1:0]      pass_ext;

  assign in_stall  = !cmd.collect;
  assign in_acc    = cmd.collect && in_valid;
  assign has_room  = count_r < CW'(DEPTH);
  assign cfg_ready = 1'b1;
  assign pass_ext  = {{(CW-AW){1'b0}}, pass_r};

  assign swap = desc_r ? (cur_r < rdata_r) : (cur_r > rdata_r);

  assign sts.last_acc  = in_acc && in_data.last;
  assign sts.scan_end  = scan_r == count_r;
  assign sts.pass_last = (pass_ext + CW'(1)) == count_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // single write port: store on collect, exchange on compare
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = in_data.value;
    if (in_acc && has_room) begin
      wr_en = 1'b1;
    end else if (cmd.sc_cmp && swap) begin
      wr_en   = 1'b1;
      wr_addr = scan_r[AW-1:0];
      wr_data = cur_r;
    end
  end

  assign rd_en   = cmd.ld_rd || cmd.sc_rd;
  assign rd_addr = cmd.ld_rd ? pass_r : scan_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (in_acc) begin
      if (has_room) begin
        count_nxt = count_r + CW'(1);
      end else begin
        dropped_nxt = 1'b1;
      end
    end else if (cmd.emit && sts.pass_last) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_data;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sts.last_acc) begin
      pass_r <= '0;
    end else if (cmd.emit) begin
      pass_r <= pass_r + AW'(1);
    end
    if (cmd.ld_cap) begin
      cur_r  <= rdata_r;
      scan_r <= pass_ext + CW'(1);
    end else if (cmd.sc_cmp) begin
      if (swap) begin
        cur_r <= rdata_r;
      end
      scan_r <= scan_r + CW'(1);
    end
    if (cmd.emit) begin
      out_r.sorted_value <= cur_r;
      out_r.last_out     <= sts.pass_last;
      out_r.overflow     <= dropped_r;
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for signed_array_sorter_core: sends runs of signed values,
// predicts each sorted run in the current order and checks every result item.
// Depends on sas_pkg and the signed_array_sorter_core RTL; reads no files.
module tb_top;

  localparam int STORE_DEPTH   = sas_pkg::DEPTH_DEF;
  // Idle cycles after the last result before touching the order register.
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid;
  logic               in_stall;
  sas_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sas_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;

  // Per-cycle odds (in percent) of a sender gap and of a receiver stall.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;

  // Sorter model state: values of the open run, drop flag, current order.
  logic signed [31:0] run_values[$];
  logic               run_dropped = 1'b0;
  logic               order_desc  = 1'b0;
  sas_pkg::out_item_t expected_sorted_q[$];

  signed_array_sorter_core #(
    .DEPTH(STORE_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Store one accepted value of the run, or drop it once the store is full.
  // On the last item, sort the kept values and queue one result per value.
  task automatic collect_and_sort(input logic signed [31:0] v, input logic is_last);
    logic signed [31:0] sorted[$];
    logic signed [31:0] key;
    sas_pkg::out_item_t res;
    int                 j;
    if (run_values.size() < STORE_DEPTH) begin
      run_values.push_back(v);
    end else begin
      run_dropped = 1'b1;
    end
    if (is_last) begin
      sorted = run_values;
      // Insertion sort; equal values end up adjacent, which is all that shows.
      for (int i = 1; i < sorted.size(); i++) begin
        key = sorted[i];
        j   = i;
        while (j > 0 && (order_desc ? (sorted[j-1] < key) : (sorted[j-1] > key))) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      for (int k = 0; k < sorted.size(); k++) begin
        res.sorted_value = sorted[k];
        res.last_out     = (k == sorted.size() - 1);
        res.overflow     = run_dropped;
        expected_sorted_q.push_back(res);
      end
      // Close the run: the store starts empty again.
      run_values.delete();
      run_dropped = 1'b0;
    end
  endtask

  // Offer one item, with random gaps ahead of it, and hold it until taken.
  // Leave in_valid high on return so back-to-back items need no extra edge.
  task automatic send_item(input logic signed [31:0] v, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data.value <= v;
    in_data.last  <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    collect_and_sort(v, is_last);
  endtask

  // Mix full-range values with the two extremes and a narrow band that
  // makes duplicates likely.
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: begin
        return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      end
      1, 2: begin
        return $signed($urandom_range(0, 6)) - 32'sd3;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_run(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(rand_value(), i == n - 1);
    end
  endtask

  // Drop valid, wait for every predicted item to come out, then let the
  // core settle back into collecting.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_sorted_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the order register only while the core is idle.
  task automatic set_order(input logic desc);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= desc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    order_desc = desc;
  endtask

  // Both extremes, zero and the values around it, in each order.
  task automatic test_extremes();
    for (int d = 0; d < 2; d++) begin
      set_order(d[0]);
      send_item(32'sh7fffffff, 1'b0);
      send_item(32'sh80000000, 1'b0);
      send_item(32'sd0,        1'b0);
      send_item(-32'sd1,       1'b0);
      send_item(32'sd1,        1'b1);
    end
  endtask

  // A run of one value: last on the first item, one result with last_out.
  task automatic test_single_value();
    send_item(32'sh80000000, 1'b1);
    send_item(32'sh7fffffff, 1'b1);
  endtask

  // Duplicates must come out next to each other.
  task automatic test_equal_values();
    set_order(1'b0);
    send_item(32'sd5,  1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd5,  1'b0);
    send_item(32'sd5,  1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(-32'sd3, 1'b1);
  endtask

  // Fill the store exactly, then overrun it by two so the last two items are dropped and
  // every result of that run carries overflow.
  task automatic test_store_capacity();
    set_order(1'b0);
    send_run(STORE_DEPTH);
    set_order(1'b1);
    send_run(STORE_DEPTH + 2);
  endtask

  // Short runs of random values; change the order between runs now and then.
  task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
    int sent = 0;
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        set_order(1'($urandom_range(0, 1)));
      end
      n = $urandom_range(1, 12);
      send_run(n);
      sent += n;
    end
  endtask

  task automatic test_random();
    run_phase(0,  0,  45);
    run_phase(54, 0,  45);
    run_phase(0,  54, 45);
    run_phase(19, 19, 45);
  endtask

  // Check each taken result against the oldest prediction and drive the
  // receiver stall for the next cycle.
  always @(posedge clk) begin : check_results
    sas_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sorted_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("unexpected item: value %0d last_out %0b overflow %0b",
                   out_data.sorted_value, out_data.last_out, out_data.overflow);
        end
      end else begin
        want = expected_sorted_q.pop_front();
        if (out_data.sorted_value !== want.sorted_value ||
            out_data.last_out !== want.last_out ||
            out_data.overflow !== want.overflow) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("mismatch: expected value %0d last_out %0b overflow %0b, got %0d %0b %0b",
                     want.sorted_value, want.last_out, want.overflow,
                     out_data.sorted_value, out_data.last_out, out_data.overflow);
          end
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_order(1'b0);
    test_extremes();
    test_single_value();
    test_equal_values();
    test_store_capacity();
    test_random();
    wait_idle();
    if (err_count == 0 && expected_sorted_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
